// ===== hw/rtl/hduart_pkg.sv =====
// ----------------------------------------------------------------------------
// hduart_pkg
// Shared types and constants for the half-duplex uart with receive fifo
// ----------------------------------------------------------------------------
package hduart_pkg;

  // configuration register width and indices
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SAMPLE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_GUARD_TICKS = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] BIT_TICKS_RST = 16'd139;
  localparam logic [CFG_W-1:0] FIRST_SAMPLE_TICKS_RST = 16'd208;
  localparam logic [CFG_W-1:0] STOP_GUARD_TICKS_RST = 16'd104;

  // parameter defaults
  localparam int RX_DEPTH_DEF = 64;
  localparam int TIMER_BITS_DEF = 16;

  // fixed field widths
  localparam int FILL_COUNT_W = 6;
  localparam int TX_SHIFT_W = 11;
  localparam int TX_BITS_W = 4;
  localparam int RX_PHASE_W = 4;

  // frame shape
  localparam logic [TX_SHIFT_W-1:0] TX_SHIFT_IDLE = 11'h7FF;
  localparam logic [TX_BITS_W-1:0] TX_BITS_NORMAL = 4'd10;
  localparam logic [TX_BITS_W-1:0] TX_BITS_BREAK = 4'd11;
  localparam logic [TX_BITS_W-1:0] TX_BITS_NONE = 4'd0;

  // receive phases: idle, waiting for data bit 1..8, stop guard
  localparam logic [RX_PHASE_W-1:0] RX_IDLE = 4'd0;
  localparam logic [RX_PHASE_W-1:0] RX_FIRST = 4'd1;
  localparam logic [RX_PHASE_W-1:0] RX_LAST = 4'd8;
  localparam logic [RX_PHASE_W-1:0] RX_STOP = 4'd9;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_MODE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_WRITE_RX   = 2'd1,
    ST_WRITE_BUSY = 2'd2,
    ST_READ_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       line_in;
    logic [7:0] data;
    logic       send_break;
    logic       tx_mode;
  } in_item_t;

  typedef struct packed {
    logic                    line_out;
    logic                    line_drive;
    logic [7:0]              read_data;
    logic [FILL_COUNT_W-1:0] fill_count;
    logic                    tx_busy;
    logic                    rx_busy;
    status_t                 status;
  } out_item_t;

endpackage

// ===== hw/rtl/hduart_ram.sv =====
// ----------------------------------------------------------------------------
// hduart_ram
// Generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hduart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/half_duplex_uart_with_rx_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// half_duplex_uart_with_rx_fifo_unit
// Single-wire half-duplex 8N1 uart with a receive ring fifo, one tick a beat
// ----------------------------------------------------------------------------
// Usage
//   in channel  : one beat is one oversampling tick of the wire, carrying the
//                 sampled line level and an optional command (write, read,
//                 set transmit mode)
//   out channel : exactly one result beat per input beat, in order: driven
//                 level, drive enable, popped byte, fifo fill, busy flags and
//                 command status
//   cfg port    : bit_ticks, first_sample_ticks and stop_guard_ticks, written
//                 with cfg_we while the block is idle
// Timing
//   one input beat per cycle while results are taken; each result is
//   registered in the output register. Every tick's work is a single pass
//   through the command, transmit and receive logic into the state and result
//   registers. The fifo head is prefetched from the ram, so reads never wait.
// Reset
//   synchronous; receive mode, fifo empty, line released high, timings back
//   to their defaults. The fifo ram itself is not cleared.
// Back-pressure
//   while the output register holds a beat that is not taken, in_ready falls
//   and the wire state simply waits; no tick is lost or repeated.
// ----------------------------------------------------------------------------
module half_duplex_uart_with_rx_fifo_unit #(
  parameter int RX_DEPTH   = hduart_pkg::RX_DEPTH_DEF,
  parameter int TIMER_BITS = hduart_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // tick channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hduart_pkg::in_item_t           in_item,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output hduart_pkg::out_item_t          out_item,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [hduart_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hduart_pkg::CFG_W-1:0]   cfg_data
);

  import hduart_pkg::*;

  localparam int PTR_W = $clog2(RX_DEPTH);
  localparam int FILL_W = PTR_W + 1;
  localparam int WIDE_W = CFG_W + TIMER_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

  // saturate to the timer range, zero acts as one tick
  function automatic logic [TIMER_BITS-1:0] load_delay(input logic [CFG_W-1:0] v);
    logic [WIDE_W-1:0]     wide;
    logic [TIMER_BITS-1:0] res;
    wide = WIDE_W'(v);
    if (wide > WIDE_W'(TIMER_MAX)) begin
      res = TIMER_MAX;
    end else begin
      res = wide[TIMER_BITS-1:0];
    end
    if (res == '0) begin
      res = TIMER_BITS'(1);
    end
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration registers
  logic [CFG_W-1:0] bit_ticks;
  logic [CFG_W-1:0] first_sample_ticks;
  logic [CFG_W-1:0] stop_guard_ticks;

  // uart state
  logic [PTR_W-1:0]      rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]      wr_ptr, wr_ptr_next;
  logic [TIMER_BITS-1:0] rx_timer, rx_timer_next;
  logic [RX_PHASE_W-1:0] rx_phase, rx_phase_next;
  logic [7:0]            rx_shift, rx_shift_next;
  logic [TIMER_BITS-1:0] tx_timer, tx_timer_next;
  logic [TX_SHIFT_W-1:0] tx_shift, tx_shift_next;
  logic [TX_BITS_W-1:0]  tx_bits_left, tx_bits_left_next;
  logic                  drive_mode, drive_mode_next;

  // fifo head prefetch with write bypass
  logic       ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0] ram_q;
  logic       byp_valid;
  logic [7:0] byp_data;
  logic [7:0] head;

  logic      in_acc;
  out_item_t res;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign head     = byp_valid ? byp_data : ram_q;

  // one tick: command, then transmitter, then receiver
  always_comb begin
    logic [TX_SHIFT_W-1:0] txs_c;
    logic [TX_BITS_W-1:0]  txb_c;
    logic [TIMER_BITS-1:0] txt_c;
    logic [TIMER_BITS-1:0] txt_dec;
    logic [RX_PHASE_W-1:0] rxp_c;
    logic [TIMER_BITS-1:0] rxt_c;
    logic [TIMER_BITS-1:0] rxt_dec;
    logic                  busy;
    logic [FILL_W-1:0]     fill;
    logic [FILL_W+FILL_COUNT_W-1:0] fill_wide;

    txs_c = tx_shift;
    txb_c = tx_bits_left;
    txt_c = tx_timer;
    rxp_c = rx_phase;
    rxt_c = rx_timer;
    drive_mode_next = drive_mode;
    rd_ptr_next = rd_ptr;
    res = '0;
    res.status = ST_OK;

    case (in_item.cmd)
      CMD_WRITE: begin
        if (!drive_mode) begin
          res.status = ST_WRITE_RX;
        end else if (tx_bits_left != TX_BITS_NONE) begin
          res.status = ST_WRITE_BUSY;
        end else begin
          // start bit low, data lsb first, stop high (ninth bit low for break)
          txs_c = {1'b1, !in_item.send_break, in_item.data, 1'b0};
          txb_c = in_item.send_break ? TX_BITS_BREAK : TX_BITS_NORMAL;
          txt_c = load_delay(bit_ticks);
        end
      end
      CMD_READ: begin
        if (rd_ptr == wr_ptr) begin
          res.status = ST_READ_EMPTY;
        end else begin
          res.read_data = head;
          rd_ptr_next = ptr_inc(rd_ptr);
        end
      end
      CMD_MODE: begin
        if (in_item.tx_mode != drive_mode) begin
          if (in_item.tx_mode) begin
            rxp_c = RX_IDLE;
            rxt_c = '0;
          end else begin
            txs_c = TX_SHIFT_IDLE;
            txb_c = TX_BITS_NONE;
            txt_c = '0;
          end
          drive_mode_next = in_item.tx_mode;
        end
      end
      default: begin
      end
    endcase

    busy = (txb_c != TX_BITS_NONE);
    res.tx_busy    = busy;
    res.line_out   = busy ? txs_c[0] : 1'b1;
    res.line_drive = drive_mode_next;

    // transmitter
    tx_shift_next     = txs_c;
    tx_bits_left_next = txb_c;
    tx_timer_next     = txt_c;
    txt_dec = txt_c - TIMER_BITS'(1);
    if (busy) begin
      tx_timer_next = txt_dec;
      if (txt_dec == '0) begin
        tx_shift_next     = {1'b1, txs_c[TX_SHIFT_W-1:1]};
        tx_bits_left_next = txb_c - TX_BITS_W'(1);
        tx_timer_next     = (tx_bits_left_next != TX_BITS_NONE) ? load_delay(bit_ticks) : '0;
      end
    end

    // receiver
    rx_phase_next = rxp_c;
    rx_timer_next = rxt_c;
    rx_shift_next = rx_shift;
    wr_ptr_next   = wr_ptr;
    ram_we        = 1'b0;
    rxt_dec = rxt_c - TIMER_BITS'(1);
    if (!drive_mode_next) begin
      if (rxp_c == RX_IDLE) begin
        if (!in_item.line_in) begin
          rx_phase_next = RX_FIRST;
          rx_timer_next = load_delay(first_sample_ticks);
        end
      end else begin
        rx_timer_next = rxt_dec;
        if (rxt_dec == '0) begin
          if (rxp_c <= RX_LAST) begin
            rx_shift_next = {in_item.line_in, rx_shift[7:1]};
            if (rxp_c == RX_LAST) begin
              // full fifo drops the byte
              if (ptr_inc(wr_ptr) != rd_ptr_next) begin
                ram_we      = in_acc;
                wr_ptr_next = ptr_inc(wr_ptr);
              end
              rx_phase_next = RX_STOP;
              rx_timer_next = load_delay(stop_guard_ticks);
            end else begin
              rx_phase_next = rxp_c + RX_PHASE_W'(1);
              rx_timer_next = load_delay(bit_ticks);
            end
          end else begin
            rx_phase_next = RX_IDLE;
          end
        end
      end
    end

    if (wr_ptr_next >= rd_ptr_next) begin
      fill = FILL_W'(wr_ptr_next) - FILL_W'(rd_ptr_next);
    end else begin
      fill = FILL_W'(wr_ptr_next) + FILL_W'(RX_DEPTH) - FILL_W'(rd_ptr_next);
    end
    fill_wide      = (FILL_W + FILL_COUNT_W)'(fill);
    res.fill_count = fill_wide[FILL_COUNT_W-1:0];
    res.rx_busy    = (rx_phase_next != RX_IDLE);
  end

  // prefetch the entry that will be at the head next cycle
  assign ram_raddr = in_acc ? rd_ptr_next : rd_ptr;

  hduart_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (rx_shift_next),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // bypass covers a byte written to the address being prefetched
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= ram_we && (wr_ptr == ram_raddr);
    end
    byp_data <= rx_shift_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks          <= BIT_TICKS_RST;
      first_sample_ticks <= FIRST_SAMPLE_TICKS_RST;
      stop_guard_ticks   <= STOP_GUARD_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_TICKS:          bit_ticks          <= cfg_data;
        REG_FIRST_SAMPLE_TICKS: first_sample_ticks <= cfg_data;
        REG_STOP_GUARD_TICKS:   stop_guard_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state advances on every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      rx_timer     <= '0;
      rx_phase     <= RX_IDLE;
      rx_shift     <= '0;
      tx_timer     <= '0;
      tx_shift     <= TX_SHIFT_IDLE;
      tx_bits_left <= TX_BITS_NONE;
      drive_mode   <= 1'b0;
    end else if (in_acc) begin
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      rx_timer     <= rx_timer_next;
      rx_phase     <= rx_phase_next;
      rx_shift     <= rx_shift_next;
      tx_timer     <= tx_timer_next;
      tx_shift     <= tx_shift_next;
      tx_bits_left <= tx_bits_left_next;
      drive_mode   <= drive_mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (in_acc) begin
      out_item <= res;
    end
  end

  // checks
  a_tx_only_in_tx_mode: assert property (@(posedge clk) disable iff (rst)
    (tx_bits_left != TX_BITS_NONE) |-> drive_mode)
    else $error("transmitter active in receive mode");

  a_rx_idle_in_tx_mode: assert property (@(posedge clk) disable iff (rst)
    drive_mode |-> (rx_phase == RX_IDLE))
    else $error("receiver active in transmit mode");

  a_rx_phase_range: assert property (@(posedge clk) disable iff (rst)
    rx_phase <= RX_STOP)
    else $error("receive phase out of range");

  a_tx_timer_live: assert property (@(posedge clk) disable iff (rst)
    (tx_bits_left != TX_BITS_NONE) |-> (tx_timer != '0))
    else $error("transmit timer stopped mid frame");

  a_rx_timer_live: assert property (@(posedge clk) disable iff (rst)
    (rx_phase != RX_IDLE) |-> (rx_timer != '0))
    else $error("receive timer stopped mid frame");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

// ===== bench/half_duplex_uart_with_rx_fifo_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_with_rx_fifo_unit_test
// Self-checking bench for the half-duplex 8N1 uart with its receive fifo.
// Every tick beat goes through a cycle-free shadow of the uart that predicts
// the result beat, which is then compared field by field. Stimulus is a short
// directed opening and then receive frames, transmit sessions and noise under
// several bit timings. Both channels idle at random, and once the result side
// holds off long enough to stall the tick channel.
// ----------------------------------------------------------------------------
module half_duplex_uart_with_rx_fifo_unit_test;
  import hduart_pkg::*;

  localparam int PTR_W = $clog2(RX_DEPTH_DEF);

  // shadow of the uart: predicts one result beat per tick beat and checks them
  class uart_tick_board;
    out_item_t due[$];
    int failures;
    logic [7:0] rx_ram [RX_DEPTH_DEF];
    logic [PTR_W-1:0] rd_at, wr_at;
    logic [TIMER_BITS_DEF-1:0] rx_count, tx_count;
    logic [RX_PHASE_W-1:0] rx_step;
    logic [7:0] rx_bits;
    logic [TX_SHIFT_W-1:0] tx_bits;
    logic [TX_BITS_W-1:0] tx_left;
    logic drive;
    logic [CFG_W-1:0] bit_len, first_len, guard_len;

    function new();
      failures = 0;
      rd_at = '0;
      wr_at = '0;
      rx_count = '0;
      tx_count = '0;
      rx_step = RX_IDLE;
      rx_bits = '0;
      tx_bits = TX_SHIFT_IDLE;
      tx_left = TX_BITS_NONE;
      drive = 1'b0;
      bit_len = BIT_TICKS_RST;
      first_len = FIRST_SAMPLE_TICKS_RST;
      guard_len = STOP_GUARD_TICKS_RST;
    endfunction

    // a zero delay still takes one tick
    function logic [TIMER_BITS_DEF-1:0] span(logic [CFG_W-1:0] v);
      return (v == '0) ? TIMER_BITS_DEF'(1) : TIMER_BITS_DEF'(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_BIT_TICKS: bit_len = v;
        REG_FIRST_SAMPLE_TICKS: first_len = v;
        REG_STOP_GUARD_TICKS: guard_len = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    // command first, then the transmitter, then the receiver
    function void take_tick(in_item_t t);
      status_t st;
      logic [7:0] rdata;
      logic busy;
      logic [PTR_W-1:0] nxt;
      out_item_t r;
      st = ST_OK;
      rdata = '0;
      case (t.cmd)
        CMD_WRITE: begin
          if (!drive) st = ST_WRITE_RX;
          else if (tx_left != TX_BITS_NONE) st = ST_WRITE_BUSY;
          else begin
            // stop, optional low ninth bit, data lsb first, start
            tx_bits = t.send_break ? {2'b10, t.data, 1'b0} : {2'b11, t.data, 1'b0};
            tx_left = t.send_break ? TX_BITS_BREAK : TX_BITS_NORMAL;
            tx_count = span(bit_len);
          end
        end
        CMD_READ: begin
          if (rd_at == wr_at) st = ST_READ_EMPTY;
          else begin
            rdata = rx_ram[rd_at];
            rd_at = rd_at + 1'b1;
          end
        end
        CMD_MODE: begin
          if (t.tx_mode != drive) begin
            if (t.tx_mode) begin
              rx_step = RX_IDLE;
              rx_count = '0;
            end else begin
              tx_bits = TX_SHIFT_IDLE;
              tx_left = TX_BITS_NONE;
              tx_count = '0;
            end
            drive = t.tx_mode;
          end
        end
        default: ;
      endcase
      busy = (tx_left != TX_BITS_NONE);
      r.line_out = busy ? tx_bits[0] : 1'b1;
      if (busy) begin
        tx_count = tx_count - 1'b1;
        if (tx_count == '0) begin
          tx_bits = {1'b1, tx_bits[TX_SHIFT_W-1:1]};
          tx_left = tx_left - 1'b1;
          tx_count = (tx_left != TX_BITS_NONE) ? span(bit_len) : '0;
        end
      end
      if (!drive) begin
        if (rx_step == RX_IDLE) begin
          if (!t.line_in) begin
            rx_step = RX_FIRST;
            rx_count = span(first_len);
          end
        end else begin
          rx_count = rx_count - 1'b1;
          if (rx_count == '0) begin
            if (rx_step <= RX_LAST) begin
              rx_bits = {t.line_in, rx_bits[7:1]};
              if (rx_step == RX_LAST) begin
                nxt = wr_at + 1'b1;
                if (nxt != rd_at) begin
                  rx_ram[wr_at] = rx_bits;
                  wr_at = nxt;
                end
                rx_step = RX_STOP;
                rx_count = span(guard_len);
              end else begin
                rx_step = rx_step + 1'b1;
                rx_count = span(bit_len);
              end
            end else begin
              rx_step = RX_IDLE;
            end
          end
        end
      end
      r.line_drive = drive;
      r.read_data = rdata;
      r.fill_count = wr_at - rd_at;
      r.tx_busy = busy;
      r.rx_busy = (rx_step != RX_IDLE);
      r.status = st;
      due.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        $error("result beat with no tick waiting");
        failures++;
        return;
      end
      want = due.pop_front();
      cmp("line_out", want.line_out, got.line_out);
      cmp("line_drive", want.line_drive, got.line_drive);
      cmp("read_data", want.read_data, got.read_data);
      cmp("fill_count", want.fill_count, got.fill_count);
      cmp("tx_busy", want.tx_busy, got.tx_busy);
      cmp("rx_busy", want.rx_busy, got.rx_busy);
      cmp("status", want.status, got.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  in_item_t in_item;
  logic out_valid, out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  uart_tick_board board = new();

  // bench view of the wire: current mode and effective bit timings
  bit in_tx = 1'b0;
  int bit_now = 139, first_now = 208, guard_now = 104;
  // idling switches, redrawn every 64 beats so quiet stretches occur too
  bit send_gaps = 1'b1, take_gaps = 1'b0;
  int sent = 0, taken = 0;

  half_duplex_uart_with_rx_fifo_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t tick_of(cmd_t c, logic line, logic [7:0] d, logic brk,
                                       logic mode);
    in_item_t it;
    it.cmd = c;
    it.line_in = line;
    it.data = d;
    it.send_break = brk;
    it.tx_mode = mode;
    return it;
  endfunction

  // fields the command ignores are filled at random
  function automatic in_item_t rnd_tick(cmd_t c, logic line);
    return tick_of(c, line, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endfunction

  // tick beat inside a receive frame: mostly plain, sometimes a read, an
  // ignored write or a set to the mode already in force
  function automatic in_item_t rx_beat(int read_pct, logic line);
    int r;
    in_item_t it;
    r = $urandom_range(0, 99);
    if (r < read_pct) it = rnd_tick(CMD_READ, line);
    else if (r < read_pct + 2) it = rnd_tick(CMD_WRITE, line);
    else if (r < read_pct + 3) begin
      it = rnd_tick(CMD_MODE, line);
      it.tx_mode = 1'b0;
    end else it = rnd_tick(CMD_TICK, line);
    return it;
  endfunction

  // offer one tick beat, changing inputs only at the falling edge
  task automatic send_tick(in_item_t it);
    int gap;
    gap = send_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.take_tick(it);
    sent++;
    if (sent % 64 == 0) send_gaps = 1'($urandom_range(0, 1));
    @(negedge clk);
  endtask

  task automatic send_noise(int n);
    in_item_t it;
    repeat (n) begin
      it = rnd_tick(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (it.cmd == CMD_MODE) in_tx = it.tx_mode;
      send_tick(it);
    end
  endtask

  // well-formed 8N1 frame with a random byte, bit length matching bit_ticks
  task automatic rx_frame(int read_pct, int extra_max);
    logic [7:0] val;
    int stop_len;
    val = 8'($urandom_range(0, 255));
    stop_len = ((bit_now > guard_now) ? bit_now : guard_now) + $urandom_range(0, extra_max);
    repeat ($urandom_range(0, extra_max)) send_tick(rx_beat(read_pct, 1'b1));
    repeat (bit_now) send_tick(rx_beat(read_pct, 1'b0));
    for (int k = 0; k < 8; k++) begin
      repeat (bit_now) send_tick(rx_beat(read_pct, val[k]));
    end
    repeat (stop_len) send_tick(rx_beat(read_pct, 1'b1));
  endtask

  // one write and ticks until the frame is out, with refused writes, reads
  // and now and then an abort back to receive mode
  task automatic tx_session(int read_pct, int extra_max);
    logic brk;
    int len, r;
    cmd_t c;
    brk = ($urandom_range(0, 3) == 0);
    send_tick(tick_of(CMD_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), brk,
                      1'($urandom_range(0, 1))));
    len = (brk ? 11 : 10) * bit_now + $urandom_range(0, extra_max);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_tick(tick_of(CMD_MODE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0));
        in_tx = 1'b0;
        return;
      end
      if (r < 7) c = CMD_WRITE;
      else if (r < 7 + read_pct) c = CMD_READ;
      else c = CMD_TICK;
      send_tick(rnd_tick(c, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_traffic(int units, int read_pct, int switch_pct, int extra_max);
    int r;
    repeat (units) begin
      r = $urandom_range(0, 99);
      if (r < switch_pct) send_noise($urandom_range(1, 6));
      else if (r < 2 * switch_pct) begin
        send_tick(tick_of(CMD_MODE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), !in_tx));
        in_tx = !in_tx;
      end else if (in_tx) tx_session(read_pct, extra_max);
      else rx_frame(read_pct, extra_max);
    end
  endtask

  // park both machines, drain, then load all three timings
  task automatic set_timing(logic [CFG_W-1:0] b, logic [CFG_W-1:0] f, logic [CFG_W-1:0] g);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0] val [3];
    idx = '{REG_BIT_TICKS, REG_FIRST_SAMPLE_TICKS, REG_STOP_GUARD_TICKS};
    val = '{b, f, g};
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b1));
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b0));
    in_tx = 1'b0;
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      board.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    bit_now = (b == 0) ? 1 : b;
    first_now = (f == 0) ? 1 : f;
    guard_now = (g == 0) ? 1 : g;
  endtask

  // result side: random stalls, and one long hold-off that backs up the ticks
  initial begin : take_results
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = take_gaps ? $urandom_range(0, 16) : 0;
      if (taken == 150) stall = 400;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_item);
      taken++;
      if (taken % 64 == 0) take_gaps = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
  end

  // hard limit, far beyond the slowest correct run
  initial begin : watchdog
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int wait_n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timings, receive mode
    send_tick(tick_of(CMD_READ, 1'b1, 8'h00, 1'b0, 1'b0));  // read from empty fifo
    send_tick(tick_of(CMD_WRITE, 1'b1, 8'hFF, 1'b1, 1'b1)); // write ignored in receive mode
    send_tick(tick_of(CMD_TICK, 1'b0, 8'h00, 1'b0, 1'b0));  // start edge, frame opens
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b1));  // enter transmit, frame dropped
    send_tick(tick_of(CMD_MODE, 1'b0, 8'hFF, 1'b1, 1'b1));  // same mode again
    send_tick(tick_of(CMD_WRITE, 1'b1, 8'h00, 1'b0, 1'b0)); // frame of zeros starts
    send_tick(tick_of(CMD_WRITE, 1'b0, 8'h5A, 1'b1, 1'b0)); // refused, still sending
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b0));  // leave transmit, frame aborted
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b0));  // same mode again

    // zero timings act as one tick
    set_timing(16'd0, 16'd0, 16'd0);
    // all-ones byte; a read in the tick it lands still sees an empty fifo
    for (int i = 0; i < 10; i++) begin
      send_tick(rnd_tick((i >= 8) ? CMD_READ : CMD_TICK, i != 0));
    end
    send_tick(tick_of(CMD_MODE, 1'b1, 8'h00, 1'b0, 1'b1));
    send_tick(tick_of(CMD_WRITE, 1'b1, 8'hFF, 1'b1, 1'b1)); // break frame

    // fastest timing, frames back to back and no reads: fifo fills, last byte drops
    set_timing(16'd1, 16'd1, 16'd1);
    run_traffic(64, 0, 0, 0);
    repeat (8) send_tick(rnd_tick(CMD_READ, 1'b1));

    set_timing(16'd2, 16'd3, 16'd1);
    run_traffic(3, 15, 10, 1);
    set_timing(16'd3, 16'd4, 16'd2);
    run_traffic(2, 12, 12, 2);
    set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)), 16'($urandom_range(1, 5)));
    run_traffic(2, 20, 15, 1);

    // longest timings: frames open but never complete here
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_noise(20);
    set_timing(BIT_TICKS_RST, FIRST_SAMPLE_TICKS_RST, STOP_GUARD_TICKS_RST);
    send_noise(8);

    // drain, then wait for any stray beat
    in_valid <= 1'b0;
    for (wait_n = 0; wait_n < 5000 && board.pending() != 0; wait_n++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (board.pending() != 0) begin
      $error("%0d result beats never arrived", board.pending());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
